[hdl/gil_pkg.sv]
// shared types and constants for the grid index linearizer
// used by gil_cell and grid_index_linearizer, depends on nothing
package gil_pkg;

  localparam int FIELD_DIMS = 4;
  localparam int IDX_W      = 32;
  localparam int RADIX_W    = 16;
  localparam int LIN_W      = 31;
  localparam int DIMS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // restoring division, a few quotient bits per cell
  localparam int CELL_STEPS = 4;
  localparam int QUO_W      = LIN_W + 1;
  localparam int DIV_CELLS  = (QUO_W + CELL_STEPS - 1) / CELL_STEPS;
  localparam int REM_W      = RADIX_W + 1;

  localparam int DEFAULT_MAX_DIMS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_3   = 3'd4;

  localparam logic [DIMS_W-1:0]  DIM_COUNT_RESET = 3'd4;
  localparam logic [RADIX_W-1:0] RADIX_RESET     = 16'd256;

  localparam logic CMD_PACK   = 1'b0;
  localparam logic CMD_UNPACK = 1'b1;

  typedef struct packed {
    logic [DIMS_W-1:0]                    dims;
    logic [FIELD_DIMS-1:0][RADIX_W-1:0]   radix;
  } cfg_t;

  typedef struct packed {
    logic                                 cmd;
    logic [FIELD_DIMS-1:0][IDX_W-1:0]     idx;
    logic [IDX_W-1:0]                     acc;
    logic                                 outside;
    logic [LIN_W-1:0]                     rest;
    logic [QUO_W-1:0]                     q;
    logic [REM_W-1:0]                     a;
    logic                                 done;
    logic [FIELD_DIMS-1:0][IDX_W-1:0]     res;
  } pipe_t;

endpackage

[hdl/gil_cell.sv]
// one stage of the linearizer chain: a few division steps for unpack,
// horner multiply-add for pack in the first cell of each group; uses gil_pkg
module gil_cell #(
  parameter int UDIM = 0,
  parameter int PDIM = 0,
  parameter int POS  = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  gil_pkg::cfg_t  cfg,
  input  logic           in_vld,
  input  gil_pkg::pipe_t in_data,
  output logic           out_vld,
  output gil_pkg::pipe_t out_data
);

  localparam logic [gil_pkg::DIMS_W:0] UDIM_L = (gil_pkg::DIMS_W+1)'(UDIM);
  localparam logic [gil_pkg::DIMS_W:0] PDIM_L = (gil_pkg::DIMS_W+1)'(PDIM);

  gil_pkg::pipe_t data_next;

  always_comb begin
    logic [gil_pkg::RADIX_W-1:0] r;
    logic [gil_pkg::RADIX_W-1:0] rp;
    logic [gil_pkg::IDX_W-1:0]   ix;
    r  = cfg.radix[UDIM];
    rp = cfg.radix[PDIM];
    ix = in_data.idx[PDIM];
    data_next = in_data;
    if (POS == 0) begin
      if (PDIM_L < {1'b0, cfg.dims}) begin
        data_next.acc = gil_pkg::IDX_W'(in_data.acc * rp) + ix + 32'd1;
        if (ix[gil_pkg::IDX_W-1] ||
            $signed({1'b0, ix}) >= $signed({17'b0, rp})) begin
          data_next.outside = 1'b1;
        end
      end
      data_next.q = {1'b0, in_data.rest};
      data_next.a = '0;
    end
    for (int s = 0; s < gil_pkg::CELL_STEPS; s++) begin
      data_next.a = {data_next.a[gil_pkg::REM_W-2:0], data_next.q[gil_pkg::QUO_W-1]};
      data_next.q = {data_next.q[gil_pkg::QUO_W-2:0], 1'b0};
      if (data_next.a >= {1'b0, r}) begin
        data_next.a    = data_next.a - {1'b0, r};
        data_next.q[0] = 1'b1;
      end
    end
    if (POS == gil_pkg::DIV_CELLS - 1) begin
      if (UDIM_L < {1'b0, cfg.dims}) begin
        if (data_next.done) begin
          data_next.res[UDIM] = '1;
        end else if (UDIM == 0 || r == '0) begin
          // top of the radix system takes the whole remaining value
          data_next.res[UDIM] = {1'b0, data_next.rest} - 32'd1;
          data_next.done      = 1'b1;
        end else begin
          data_next.res[UDIM] = {16'b0, data_next.a[gil_pkg::RADIX_W-1:0]} - 32'd1;
          data_next.rest      = data_next.q[gil_pkg::LIN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

[hdl/grid_index_linearizer.sv]
// top level of the grid index linearizer: config registers and a chain of cells
// depends on gil_pkg and gil_cell
//
//  channel | handshake            | payload
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | command, index_0..3, linear_in
//  out     | out_valid/out_ready  | linear_out, out_index_0..3, outside
//
// one beat per cycle while out is not stalled; each dimension
// has a group of 8 cells, the divider taking 4 quotient bits per cell
// the whole chain advances together and holds while out is stalled
// synchronous reset clears valids and sets dim_count 4 and radices 256
module grid_index_linearizer #(
  parameter int MAX_DIMS = gil_pkg::DEFAULT_MAX_DIMS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gil_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gil_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic signed [31:0]              index_0,
  input  logic signed [31:0]              index_1,
  input  logic signed [31:0]              index_2,
  input  logic signed [31:0]              index_3,
  input  logic [30:0]                     linear_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              linear_out,
  output logic signed [31:0]              out_index_0,
  output logic signed [31:0]              out_index_1,
  output logic signed [31:0]              out_index_2,
  output logic signed [31:0]              out_index_3,
  output logic                            outside
);

  localparam int GROUPS = (MAX_DIMS < gil_pkg::FIELD_DIMS) ? MAX_DIMS : gil_pkg::FIELD_DIMS;
  localparam int STAGES = GROUPS * gil_pkg::DIV_CELLS;

  logic [gil_pkg::DIMS_W-1:0]                      dim_count;
  logic [gil_pkg::FIELD_DIMS-1:0][gil_pkg::RADIX_W-1:0] radix;
  gil_pkg::cfg_t  cfg;
  gil_pkg::pipe_t head;
  logic           en;

  logic           vld [STAGES+1];
  gil_pkg::pipe_t dat [STAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= gil_pkg::DIM_COUNT_RESET;
      for (int i = 0; i < gil_pkg::FIELD_DIMS; i++) begin
        radix[i] <= gil_pkg::RADIX_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index == gil_pkg::REG_DIM_COUNT) begin
        dim_count <= cfg_data[gil_pkg::DIMS_W-1:0];
      end else if (cfg_index >= gil_pkg::REG_RADIX_0 && cfg_index <= gil_pkg::REG_RADIX_3) begin
        radix[2'(cfg_index - gil_pkg::REG_RADIX_0)] <= cfg_data;
      end
    end
  end

  // zero acts as one, large counts saturate
  always_comb begin
    cfg.radix = radix;
    if (dim_count == '0) begin
      cfg.dims = 3'd1;
    end else if (dim_count > 3'(GROUPS)) begin
      cfg.dims = 3'(GROUPS);
    end else begin
      cfg.dims = dim_count;
    end
  end

  always_comb begin
    head         = '0;
    head.cmd     = command;
    head.idx[0]  = index_0;
    head.idx[1]  = index_1;
    head.idx[2]  = index_2;
    head.idx[3]  = index_3;
    head.rest    = linear_in;
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign vld[0]   = in_valid;
  assign dat[0]   = head;

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    for (genvar c = 0; c < gil_pkg::DIV_CELLS; c++) begin : g_cell
      gil_cell #(
        .UDIM(GROUPS - 1 - g),
        .PDIM(g),
        .POS (c)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .cfg     (cfg),
        .in_vld  (vld[g*gil_pkg::DIV_CELLS + c]),
        .in_data (dat[g*gil_pkg::DIV_CELLS + c]),
        .out_vld (vld[g*gil_pkg::DIV_CELLS + c + 1]),
        .out_data(dat[g*gil_pkg::DIV_CELLS + c + 1])
      );
    end
  end

  assign out_valid   = vld[STAGES];
  assign linear_out  = (dat[STAGES].cmd == gil_pkg::CMD_PACK) ? dat[STAGES].acc : '0;
  assign outside     = (dat[STAGES].cmd == gil_pkg::CMD_PACK) ? dat[STAGES].outside : 1'b0;
  assign out_index_0 = (dat[STAGES].cmd == gil_pkg::CMD_UNPACK) ? dat[STAGES].res[0] : '0;
  assign out_index_1 = (dat[STAGES].cmd == gil_pkg::CMD_UNPACK) ? dat[STAGES].res[1] : '0;
  assign out_index_2 = (dat[STAGES].cmd == gil_pkg::CMD_UNPACK) ? dat[STAGES].res[2] : '0;
  assign out_index_3 = (dat[STAGES].cmd == gil_pkg::CMD_UNPACK) ? dat[STAGES].res[3] : '0;

endmodule
